// File: src/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Operation codes, status codes, cell commands and the fixed field widths
// of the item ports.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

   localparam int FUNC_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int KEY_BITS    = 32;
   localparam int POS_BITS    = 6;
   localparam int COUNT_BITS  = 7;
   localparam int REQ_BITS    = 40;
   localparam int RSP_BITS    = 104;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_READ   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2,
      ST_BADIDX  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_REMOVE = 2'd2,
      CELL_CLEAR  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        commit;
   } row_ctrl_type;

endpackage

`default_nettype wire

// File: src/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds one key and its valid flag, compares it with the broadcast key and
// takes a key from its upper or lower neighbor to open or close a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell #(
   parameter int KEY_WIDTH = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  skt_pkg::row_ctrl_type    ctrl,
   input  wire  [KEY_WIDTH-1:0]     key,
   input  wire                      prev_gt,
   input  wire                      prev_valid,
   input  wire  [KEY_WIDTH-1:0]     prev_entry,
   input  wire                      next_valid,
   input  wire  [KEY_WIDTH-1:0]     next_entry,
   output logic [KEY_WIDTH-1:0]     entry,
   output logic                     valid,
   output logic                     gt,
   output logic                     eq
);

   logic [KEY_WIDTH-1:0] entry_ff;
   logic [KEY_WIDTH-1:0] entry_in;
   logic                 valid_ff;
   logic                 valid_in;

   always_comb begin
      gt       = valid_ff && (entry_ff > key);
      eq       = valid_ff && (entry_ff == key);
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.commit) begin
         case (ctrl.op)
            skt_pkg::CELL_INSERT: begin
               if (!gt) begin
                  entry_in = prev_gt ? key : prev_entry;
                  valid_in = prev_valid;
               end
            end
            skt_pkg::CELL_REMOVE: begin
               if (!gt) begin
                  entry_in = next_entry;
                  valid_in = next_valid;
               end
            end
            skt_pkg::CELL_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
               entry_in = entry_ff;
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

`default_nettype wire

// File: src/skt_row.sv
// ----------------------------------------------------------------------------
// skt_row: the chain of key cells
// Links the cells to their neighbors and gathers the remove hit, the key at
// a read index, and the top and bottom keys of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_row #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  wire                              clock,
   input  wire                              reset,
   input  skt_pkg::row_ctrl_type            ctrl,
   input  wire  [KEY_WIDTH-1:0]             key,
   input  wire  [skt_pkg::POS_BITS-1:0]     position,
   output logic                             found,
   output logic [KEY_WIDTH-1:0]             read_key,
   output logic [KEY_WIDTH-1:0]             top_key,
   output logic [KEY_WIDTH-1:0]             bottom_key
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (IDX_W > skt_pkg::POS_BITS) ? IDX_W : skt_pkg::POS_BITS;

   logic [KEY_WIDTH-1:0] ent [CAPACITY];
   logic [CAPACITY-1:0]  valid_vec;
   logic [CAPACITY-1:0]  gt_vec;
   logic [CAPACITY-1:0]  eq_vec;
   logic [CAPACITY:0]    gt_prev;
   logic [CAPACITY:0]    valid_prev;
   logic [CAPACITY:0]    valid_next;

   assign gt_prev    = {gt_vec, 1'b1};
   assign valid_prev = {valid_vec, 1'b1};
   assign valid_next = {1'b0, valid_vec};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] prev_entry;
      logic [KEY_WIDTH-1:0] next_entry;

      if (i == 0) begin : g_first
         assign prev_entry = key;
      end else begin : g_mid
         assign prev_entry = ent[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign next_entry = ent[i];
      end else begin : g_inner
         assign next_entry = ent[i+1];
      end

      skt_cell #(
         .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key        (key),
         .prev_gt    (gt_prev[i]),
         .prev_valid (valid_prev[i]),
         .prev_entry (prev_entry),
         .next_valid (valid_next[i+1]),
         .next_entry (next_entry),
         .entry      (ent[i]),
         .valid      (valid_vec[i]),
         .gt         (gt_vec[i]),
         .eq         (eq_vec[i])
      );
   end

   assign found   = |(eq_vec & gt_prev[CAPACITY-1:0]);
   assign top_key = valid_vec[0] ? ent[0] : '0;

   always_comb begin
      read_key   = '0;
      bottom_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (valid_vec[i] && (CMP_W'(i) == CMP_W'(position))) begin
            read_key = read_key | ent[i];
         end
         if (valid_vec[i] && !valid_next[i+1]) begin
            bottom_key = bottom_key | ent[i];
         end
      end
   end

endmodule

`default_nettype wire

// File: src/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: table of keys kept in descending order
// Inserts, removes, reads by index and clears a sorted set of keys held in
// a chain of compare-and-shift cells; each item returns one result item.
//
//   Channel  Direction  tdata (low bit up)                     tuser
//   req_     in         key[31:0], position[37:32]              func
//   rsp_     out        read_key, top_key, bottom_key, count   status
//
// Every cell compares and shifts at once when an item is taken.
// Its result item passes through a pending register and then the output
// register; one item may be accepted every cycle while the result side keeps up.
// A held result stalls the input only once a second result waits behind it.
// Reset empties the table at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table #(
   parameter int CAPACITY  = 64,
   parameter int KEY_WIDTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // key, position
   input  wire  [skt_pkg::REQ_BITS-1:0]        req_tdata,
   // func
   input  wire  [skt_pkg::FUNC_BITS-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // read_key, top_key, bottom_key, entry_count
   output logic [skt_pkg::RSP_BITS-1:0]        rsp_tdata,
   // status
   output logic [skt_pkg::STATUS_BITS-1:0]     rsp_tuser
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > skt_pkg::POS_BITS) ? CNT_W : skt_pkg::POS_BITS;

   skt_pkg::func_type              func;
   skt_pkg::row_ctrl_type          ctrl;
   skt_pkg::status_type            status;
   logic [KEY_WIDTH-1:0]           key;
   logic [skt_pkg::POS_BITS-1:0]   position;
   logic                           accept;
   logic                           out_free;
   logic                           full;
   logic                           found;
   logic [KEY_WIDTH-1:0]           row_read;
   logic [KEY_WIDTH-1:0]           row_top;
   logic [KEY_WIDTH-1:0]           row_bottom;
   logic [skt_pkg::KEY_BITS-1:0]   read_val;

   logic [CNT_W-1:0]               count_ff;
   logic [CNT_W-1:0]               count_in;
   logic                           pend_ff;
   logic                           pend_in;
   skt_pkg::status_type            pend_status_ff;
   logic [skt_pkg::KEY_BITS-1:0]   pend_read_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   skt_pkg::status_type            out_status_ff;
   logic [skt_pkg::KEY_BITS-1:0]   out_read_ff;
   logic [skt_pkg::KEY_BITS-1:0]   out_top_ff;
   logic [skt_pkg::KEY_BITS-1:0]   out_bottom_ff;
   logic [CNT_W-1:0]               out_count_ff;

   assign func     = skt_pkg::func_type'(req_tuser);
   assign key      = KEY_WIDTH'(req_tdata[skt_pkg::KEY_BITS-1:0]);
   assign position = req_tdata[skt_pkg::KEY_BITS +: skt_pkg::POS_BITS];
   assign out_free = !out_valid_ff || rsp_tready;
   assign req_tready = !pend_ff || out_free;
   assign accept   = req_tvalid && req_tready;
   assign full     = (count_ff == CNT_W'(CAPACITY));

   skt_row #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_row (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .key        (key),
      .position   (position),
      .found      (found),
      .read_key   (row_read),
      .top_key    (row_top),
      .bottom_key (row_bottom)
   );

   always_comb begin
      ctrl.commit = accept;
      ctrl.op     = skt_pkg::CELL_HOLD;
      status      = skt_pkg::ST_OK;
      read_val    = '0;
      count_in    = count_ff;
      unique case (func)
         skt_pkg::FUNC_INSERT: begin
            if (full) begin
               status = skt_pkg::ST_FULL;
            end else begin
               ctrl.op  = skt_pkg::CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         skt_pkg::FUNC_REMOVE: begin
            if (found) begin
               ctrl.op  = skt_pkg::CELL_REMOVE;
               count_in = count_ff - CNT_W'(1);
            end else begin
               status = skt_pkg::ST_MISSING;
            end
         end
         skt_pkg::FUNC_READ: begin
            if (CMP_W'(position) < CMP_W'(count_ff)) begin
               read_val = skt_pkg::KEY_BITS'(row_read);
            end else begin
               status = skt_pkg::ST_BADIDX;
            end
         end
         skt_pkg::FUNC_CLEAR: begin
            ctrl.op  = skt_pkg::CELL_CLEAR;
            count_in = '0;
         end
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (out_free) begin
         pend_in = 1'b0;
      end
      out_valid_in = out_free ? pend_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= status;
         pend_read_ff   <= read_val;
      end
      if (out_free && pend_ff) begin
         out_status_ff <= pend_status_ff;
         out_read_ff   <= pend_read_ff;
         out_top_ff    <= skt_pkg::KEY_BITS'(row_top);
         out_bottom_ff <= skt_pkg::KEY_BITS'(row_bottom);
         out_count_ff  <= count_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = skt_pkg::RSP_BITS'({skt_pkg::COUNT_BITS'(out_count_ff), out_bottom_ff,
                                           out_top_ff, out_read_ff});

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the sorted key table
// A table of directed items covers the empty, single, extreme and duplicate
// key cases, then random bursts grow, shrink and churn the table. Each
// accepted request item is run through a local model of the descending
// key table, and every response item is compared field by field with the
// oldest expected response.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int TABLE_DEPTH  = 64;
   localparam int CNT_W        = skt_pkg::COUNT_BITS;
   localparam int RSP_W        = skt_pkg::RSP_BITS;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      skt_pkg::status_type status;
      logic [31:0]         read_key;
      logic [31:0]         top_key;
      logic [31:0]         bottom_key;
      logic [CNT_W-1:0]    entry_count;
   } result_type;

   typedef struct packed {
      skt_pkg::func_type   func;
      logic [31:0]         key;
      logic [5:0]          position;
      logic                typed;
      result_type          want;
   } stimulus_type;

   typedef enum int {GROW, SHRINK, CHURN} burst_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   wire                             req_tready;
   logic [skt_pkg::REQ_BITS-1:0]    req_tdata = '0;
   logic [skt_pkg::FUNC_BITS-1:0]   req_tuser = '0;
   wire                             rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   wire  [RSP_W-1:0]                rsp_tdata;
   wire  [skt_pkg::STATUS_BITS-1:0] rsp_tuser;

   logic [31:0]   keys_held [TABLE_DEPTH];
   int            keys_filled = 0;
   result_type    expected_results [$];
   int            failures = 0;

   sorted_key_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      int cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("sorted_key_table: mismatch");
            $finish;
         end
      end
   end

   // Applies one operation to the local copy of the table and returns the
   // response item it should produce.
   function automatic result_type apply_table_op(skt_pkg::func_type f, logic [31:0] k,
                                                 logic [5:0] p);
      result_type r;
      int         loc;
      r = '0;
      r.status = skt_pkg::ST_OK;
      case (f)
         skt_pkg::FUNC_INSERT: begin
            if (keys_filled >= TABLE_DEPTH) begin
               r.status = skt_pkg::ST_FULL;
            end else begin
               loc = 0;
               while (loc < keys_filled && keys_held[loc] > k) loc++;
               for (int i = keys_filled; i > loc; i--) keys_held[i] = keys_held[i-1];
               keys_held[loc] = k;
               keys_filled++;
            end
         end
         skt_pkg::FUNC_REMOVE: begin
            loc = 0;
            while (loc < keys_filled && keys_held[loc] != k) loc++;
            if (loc >= keys_filled) begin
               r.status = skt_pkg::ST_MISSING;
            end else begin
               for (int i = loc; i + 1 < keys_filled; i++) keys_held[i] = keys_held[i+1];
               keys_filled--;
            end
         end
         skt_pkg::FUNC_READ: begin
            if (p < keys_filled) r.read_key = keys_held[p];
            else r.status = skt_pkg::ST_BADIDX;
         end
         default: begin
            keys_filled = 0;
         end
      endcase
      r.top_key     = (keys_filled > 0) ? keys_held[0] : 32'd0;
      r.bottom_key  = (keys_filled > 0) ? keys_held[keys_filled-1] : 32'd0;
      r.entry_count = keys_filled[CNT_W-1:0];
      return r;
   endfunction

   function automatic stimulus_type row_open(skt_pkg::func_type f, logic [31:0] k,
                                             logic [5:0] p);
      stimulus_type s;
      s = '0;
      s.func     = f;
      s.key      = k;
      s.position = p;
      return s;
   endfunction

   function automatic stimulus_type row_typed(skt_pkg::func_type f, logic [31:0] k,
                                              logic [5:0] p, skt_pkg::status_type st,
                                              logic [31:0] top, logic [31:0] bottom,
                                              int count);
      stimulus_type s;
      s = row_open(f, k, p);
      s.typed            = 1'b1;
      s.want.status      = st;
      s.want.top_key     = top;
      s.want.bottom_key  = bottom;
      s.want.entry_count = count[CNT_W-1:0];
      return s;
   endfunction

   function automatic logic [31:0] pick_key();
      logic [31:0] k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: k = $urandom_range(0, 15);
         4: begin
            case ($urandom_range(0, 3))
               0: k = 32'h0000_0000;
               1: k = 32'hFFFF_FFFF;
               2: k = 32'h8000_0000;
               default: k = 32'h7FFF_FFFF;
            endcase
         end
         5, 6: k = (keys_filled > 0) ? keys_held[$urandom_range(0, keys_filled - 1)]
                                     : $urandom();
         default: k = $urandom();
      endcase
      return k;
   endfunction

   task automatic send_item(skt_pkg::func_type f, logic [31:0] k, logic [5:0] p, int gap,
                            logic typed, result_type typed_want);
      result_type predicted;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, p, k};
      req_tuser  <= f;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = apply_table_op(f, k, p);
      expected_results.push_back(typed ? typed_want : predicted);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("response item with no request waiting for it");
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_tuser));
            check_field("read_key", want.read_key, rsp_tdata[31:0]);
            check_field("top_key", want.top_key, rsp_tdata[63:32]);
            check_field("bottom_key", want.bottom_key, rsp_tdata[95:64]);
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_tdata[102:96]));
         end
      end
   end

   initial begin
      int served;
      int stall;
      bit steady;
      served = 0;
      steady = 1'b0;
      forever begin
         if (served % 40 == 0) steady = ($urandom_range(0, 3) == 0);
         stall = steady ? 0 : $urandom_range(0, 14);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         served++;
      end
   end

   initial begin
      stimulus_type      rows [21];
      result_type        no_typed;
      burst_type         mode;
      skt_pkg::func_type f;
      logic [31:0]       k;
      logic [5:0]        p;
      int                sent;
      int                burst;
      int                run_len;
      int                pick;
      bit                steady;

      no_typed = '0;
      rows[0]  = row_typed(skt_pkg::FUNC_READ, 32'h0, 6'd0, skt_pkg::ST_BADIDX,
                           32'h0, 32'h0, 0);
      rows[1]  = row_typed(skt_pkg::FUNC_REMOVE, 32'h5, 6'd0, skt_pkg::ST_MISSING,
                           32'h0, 32'h0, 0);
      rows[2]  = row_typed(skt_pkg::FUNC_CLEAR, 32'h0, 6'd0, skt_pkg::ST_OK,
                           32'h0, 32'h0, 0);
      rows[3]  = row_typed(skt_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 6'd0, skt_pkg::ST_OK,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      rows[4]  = row_typed(skt_pkg::FUNC_INSERT, 32'h0, 6'd0, skt_pkg::ST_OK,
                           32'hFFFF_FFFF, 32'h0, 2);
      rows[5]  = row_open(skt_pkg::FUNC_INSERT, 32'h8000_0000, 6'd0);
      rows[6]  = row_open(skt_pkg::FUNC_INSERT, 32'h8000_0000, 6'd63);
      rows[7]  = row_open(skt_pkg::FUNC_INSERT, 32'h7FFF_FFFF, 6'd0);
      rows[8]  = row_open(skt_pkg::FUNC_READ, 32'h0, 6'd0);
      rows[9]  = row_open(skt_pkg::FUNC_READ, 32'h0, 6'd4);
      rows[10] = row_open(skt_pkg::FUNC_READ, 32'h0, 6'd5);
      rows[11] = row_open(skt_pkg::FUNC_READ, 32'hFFFF_FFFF, 6'd63);
      rows[12] = row_open(skt_pkg::FUNC_REMOVE, 32'h8000_0000, 6'd0);
      rows[13] = row_open(skt_pkg::FUNC_REMOVE, 32'h1234_5678, 6'd0);
      rows[14] = row_open(skt_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 6'd0);
      rows[15] = row_open(skt_pkg::FUNC_REMOVE, 32'h0, 6'd0);
      rows[16] = row_open(skt_pkg::FUNC_INSERT, 32'h5555_5555, 6'd42);
      rows[17] = row_open(skt_pkg::FUNC_INSERT, 32'hAAAA_AAAA, 6'd21);
      rows[18] = row_open(skt_pkg::FUNC_READ, 32'h0, 6'd1);
      rows[19] = row_typed(skt_pkg::FUNC_CLEAR, 32'h0, 6'd0, skt_pkg::ST_OK,
                           32'h0, 32'h0, 0);
      rows[20] = row_typed(skt_pkg::FUNC_READ, 32'h0, 6'd0, skt_pkg::ST_BADIDX,
                           32'h0, 32'h0, 0);

      while (reset) @(negedge clock);

      foreach (rows[i]) begin
         send_item(rows[i].func, rows[i].key, rows[i].position, $urandom_range(0, 14),
                   rows[i].typed, rows[i].want);
      end

      // The first burst only inserts, so the table is driven past full early.
      sent  = 0;
      burst = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 2))
            0: mode = GROW;
            1: mode = SHRINK;
            default: mode = CHURN;
         endcase
         if (burst == 0) mode = GROW;
         run_len = (burst == 0) ? 72 : $urandom_range(20, 80);
         steady  = ($urandom_range(0, 3) == 0);
         for (int j = 0; j < run_len; j++) begin
            pick = (burst == 0) ? 0 : $urandom_range(0, 99);
            case (mode)
               GROW: begin
                  if (pick < 80) f = skt_pkg::FUNC_INSERT;
                  else if (pick < 88) f = skt_pkg::FUNC_REMOVE;
                  else if (pick < 99) f = skt_pkg::FUNC_READ;
                  else f = skt_pkg::FUNC_CLEAR;
               end
               SHRINK: begin
                  if (pick < 65) f = skt_pkg::FUNC_REMOVE;
                  else if (pick < 92) f = skt_pkg::FUNC_READ;
                  else f = skt_pkg::FUNC_INSERT;
               end
               default: begin
                  if (pick < 40) f = skt_pkg::FUNC_INSERT;
                  else if (pick < 65) f = skt_pkg::FUNC_REMOVE;
                  else if (pick < 97) f = skt_pkg::FUNC_READ;
                  else f = skt_pkg::FUNC_CLEAR;
               end
            endcase
            k = pick_key();
            if (f == skt_pkg::FUNC_REMOVE && keys_filled > 0 && $urandom_range(0, 3) != 0)
               k = keys_held[$urandom_range(0, keys_filled - 1)];
            p = $urandom_range(0, 63);
            if (f == skt_pkg::FUNC_READ && keys_filled > 0 && $urandom_range(0, 2) != 0)
               p = $urandom_range(0, keys_filled - 1);
            send_item(f, k, p, steady ? 0 : $urandom_range(0, 14), 1'b0, no_typed);
            sent++;
         end
         burst++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("sorted_key_table: match");
      end else begin
         $display("sorted_key_table: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
src/skt_pkg.sv
src/skt_cell.sv
src/skt_row.sv
src/sorted_key_table.sv
tb/tb.sv
